// File: design/assert_macros.svh
// Assertion helpers used by the hash core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("assertion failed");
`define ASSERT_CLK_NR(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_CLK_NR(label, clk, prop)
`endif
`endif

// File: design/fkash_pkg.sv
package fkash_pkg;

  localparam int NumRounds = 10;
  localparam logic [0:0] RegKeyLow = 1'b0;
  localparam logic [0:0] RegKeyHigh = 1'b1;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // One cipher round; byte i sits at bits 8i+7:8i.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [7:0] t [16];
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4*c] = SBOX[s[8*(r + 4*((c + r) % 4)) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c];
      a1 = t[4*c+1];
      a2 = t[4*c+2];
      a3 = t[4*c+3];
      all = a0 ^ a1 ^ a2 ^ a3;
      if (last) begin
        o[32*c +: 32] = {a3, a2, a1, a0};
      end else begin
        o[32*c +: 8] = a0 ^ all ^ xtime(a0 ^ a1);
        o[32*c+8 +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
        o[32*c+16 +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
        o[32*c+24 +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    return o ^ rk;
  endfunction

  // Next round key from the previous one and the round constant.
  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] t;
    logic [127:0] o;
    t = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]], SBOX[k[111:104]] ^ rc};
    o[31:0] = k[31:0] ^ t;
    o[63:32] = k[63:32] ^ o[31:0];
    o[95:64] = k[95:64] ^ o[63:32];
    o[127:96] = k[127:96] ^ o[95:64];
    return o;
  endfunction

endpackage

// File: design/fkash_key_sched.sv
module fkash_key_sched (
  input  logic         clk,
  input  logic [127:0] key,
  output logic [127:0] round_keys [fkash_pkg::NumRounds + 1]
);

  // Round keys are registered in a chain from the held key; the user must
  // change it only while idle (not enforced) so the chain settles in time.
  always_ff @(posedge clk) begin
    round_keys[0] <= key;
    for (int i = 1; i <= fkash_pkg::NumRounds; i++) begin
      round_keys[i] <= fkash_pkg::next_key(round_keys[i-1], fkash_pkg::RCON[i-1]);
    end
  end

endmodule

// File: design/fixed_key_aes_sigma_hash_core.sv
// Fixed-key AES-128 hash with the sigma orthomorphism.
// Configuration: write key_low at index 0 and key_high at index 1 through
// cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high. The
// user must write keys only while no seed is in flight (not enforced).
// After each key write, and after reset, busy is high for one cycle while
// the first round key register takes the new key; the later round keys
// follow one stage per cycle, just ahead of the first seed that uses them.
// Seeds: a transaction is taken when start is high and busy is low. Outside
// the cycle after a key write or reset, busy stays low, so one seed may
// enter every cycle.
// Results: hash_low and hash_high are valid for one cycle while done is
// high. A seed passes one input stage and ten round stages, then the
// output registers, which raise done and present the result together.
// Results leave in order, one per cycle at most; the receiver cannot
// stall, so no backpressure exists.
// Reset clears both key registers and all stage valid bits; items in
// flight are dropped.
`include "assert_macros.svh"
module fixed_key_aes_sigma_hash_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] seed_low,
  input  logic [63:0] seed_high,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        done,
  output logic [63:0] hash_low,
  output logic [63:0] hash_high
);

  localparam int Nr = fkash_pkg::NumRounds;

  logic [63:0]  key_low;
  logic [63:0]  key_high;
  logic         key_settling;
  logic [127:0] round_keys [Nr + 1];
  logic         valid [Nr + 1];
  logic [127:0] state [Nr + 1];
  logic [127:0] sigma [Nr + 1];
  logic [127:0] sig_in;

  assign busy = key_settling;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low <= '0;
      key_high <= '0;
      key_settling <= 1'b1;
    end else begin
      key_settling <= cfg_valid;
      if (cfg_valid) begin
        unique case (cfg_index)
          fkash_pkg::RegKeyLow: key_low <= cfg_data;
          fkash_pkg::RegKeyHigh: key_high <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  fkash_key_sched u_key_sched (
    .clk(clk),
    .key({key_high, key_low}),
    .round_keys(round_keys)
  );

  assign sig_in = {seed_high ^ seed_low, seed_high};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= Nr; i++) begin
        valid[i] <= 1'b0;
      end
      done <= 1'b0;
    end else begin
      valid[0] <= start && !busy;
      for (int i = 1; i <= Nr; i++) begin
        valid[i] <= valid[i-1];
      end
      done <= valid[Nr];
    end
  end

  always_ff @(posedge clk) begin
    state[0] <= sig_in ^ round_keys[0];
    sigma[0] <= sig_in;
    for (int i = 1; i <= Nr; i++) begin
      state[i] <= fkash_pkg::aes_round(state[i-1], round_keys[i], i == Nr);
      sigma[i] <= sigma[i-1];
    end
    hash_low <= state[Nr][63:0] ^ sigma[Nr][63:0];
    hash_high <= state[Nr][127:64] ^ sigma[Nr][127:64];
  end

  `ASSERT_CLK(a_done_follows_stage, clk, rst, done == $past(valid[Nr]))
  `ASSERT_CLK(a_entry_tracks_start, clk, rst, $past(!rst) |-> valid[0] == $past(start && !busy))
  `ASSERT_CLK(a_busy_after_cfg, clk, rst, $past(cfg_valid) |-> busy)
  `ASSERT_CLK_NR(a_reset_clears, clk, $past(rst) && !rst |-> !done && !valid[0])

endmodule
